// ===== hw/rtl/tsws_pkg.sv =====
// ----------------------------------------------------------------------------
// tsws_pkg
// Shared widths, constants and register indexes of the timestamp window
// synchronizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsws_pkg;

  // Slot store geometry
  localparam int unsigned MaxStreams = 8;
  localparam int unsigned SlotW      = $clog2(MaxStreams);
  localparam int unsigned CountW     = 4;
  localparam int unsigned StampBits  = 48;
  localparam int unsigned HandleBits = 32;
  localparam int unsigned SeqBits    = 32;
  localparam int unsigned EntryW     = StampBits + HandleBits;

  // Stream channel layouts
  localparam int unsigned InDataW  = 88;   // 4 + 48 + 32, padded to bytes
  localparam int unsigned OutDataW = 120;  // 3 + 32 + 32 + 48, padded to bytes

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 48;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStreamCount = 1'b0,
    CfgSyncWindow  = 1'b1
  } cfg_reg_e;

  typedef logic [StampBits-1:0]  stamp_t;
  typedef logic [HandleBits-1:0] handle_t;
  typedef logic [SeqBits-1:0]    seq_t;
  typedef logic [SlotW-1:0]      slot_t;
  typedef logic [CountW-1:0]     count_t;

endpackage

`default_nettype wire

// ===== hw/rtl/timestamp_window_synchronizer.sv =====
// ----------------------------------------------------------------------------
// timestamp_window_synchronizer
// Gathers one message per stream and emits a pack once all stamps fall
// inside the configured window.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one request per message, carrying stream index,
//   stamp and handle. A request for a stream at or above stream_count is
//   dropped. After a buffered request the block is ready again in the next
//   cycle unless every configured slot is now filled.
//   When all slots are filled, the slot memory is swept once (stream_count
//   reads, one per cycle, then the drain and window compare states).
//   If the spread is below sync_window, the slots are read again one at a
//   time and one result per stream goes out on m_axis, the last one flagged
//   by tlast. The throughput is set by the single read port of the slot
//   memory. A result stalled by m_axis_tready holds in the output register;
//   the read-out of the next result waits for it. The next input request is
//   taken while the final result of a pack is still waiting.
//   Reset clears all slot valid marks and the sequence, sets stream_count to
//   one and sync_window to zero. The user must write configuration only
//   when idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_window_synchronizer (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Configuration write port
  input  wire                               cfg_we_i,
  input  wire  [tsws_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [tsws_pkg::CfgDataW-1:0]     cfg_data_i,
  // Input stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] stream_index, [51:4] stamp, [83:52] message_handle, zero pad
  input  wire  [tsws_pkg::InDataW-1:0]      s_axis_tdata,
  // Result stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // [2:0] out_stream, [34:3] out_handle, [66:35] pack_sequence,
  // [114:67] pack_stamp, zero pad
  output logic [tsws_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                              m_axis_tlast   // pack_last
);

  import tsws_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StCheck,
    StRead,
    StSend
  } state_e;

  // Input field split
  logic [CountW-1:0] in_idx;
  stamp_t            in_stamp;
  handle_t           in_handle;

  assign in_idx    = s_axis_tdata[3:0];
  assign in_stamp  = s_axis_tdata[51:4];
  assign in_handle = s_axis_tdata[83:52];

  // Registers
  state_e                state_q;
  logic [MaxStreams-1:0] slot_valid_q;
  count_t                count_q;
  stamp_t                window_q;
  seq_t                  seq_q;
  slot_t                 ptr_q;
  stamp_t                min_q;
  stamp_t                max_q;
  logic                  scan_vld_q;
  logic                  out_valid_q;
  slot_t                 out_stream_q;
  handle_t               out_handle_q;
  seq_t                  out_seq_q;
  stamp_t                out_stamp_q;
  logic                  out_last_q;

  // Slot memory
  logic [EntryW-1:0] mem_q [MaxStreams];
  logic [EntryW-1:0] rd_data_q;
  logic              rd_en;
  stamp_t            rd_stamp;
  handle_t           rd_handle;

  // Control helpers
  logic                  in_acc;
  logic                  idx_ok;
  logic [MaxStreams-1:0] cnt_mask;
  logic [MaxStreams-1:0] valid_upd;
  logic                  all_valid;
  slot_t                 last_idx;
  stamp_t                spread;
  logic                  out_free;
  logic                  load_out;
  logic                  load_last;
  logic                  count_wr;
  count_t                cfg_count;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign idx_ok        = (in_idx < count_q);
  assign last_idx      = SlotW'(count_q - count_t'(1));
  assign rd_en         = (state_q == StScan) || (state_q == StRead);
  assign rd_stamp      = rd_data_q[EntryW-1:HandleBits];
  assign rd_handle     = rd_data_q[HandleBits-1:0];
  assign spread        = max_q - min_q;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign count_wr      = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == CfgStreamCount);
  assign load_out      = (state_q == StSend) && out_free && !count_wr;
  assign load_last     = load_out && (ptr_q == last_idx);

  // Slots in use and the valid marks after this request
  always_comb begin
    for (int i = 0; i < MaxStreams; i++) begin
      cnt_mask[i] = (count_t'(i) < count_q);
    end
    valid_upd = slot_valid_q;
    valid_upd[in_idx[SlotW-1:0]] = 1'b1;
    all_valid = &(valid_upd | ~cnt_mask);
  end

  // Stream count write: zero acts as one, large values saturate
  always_comb begin
    cfg_count = cfg_data_i[CountW-1:0];
    if (cfg_count == count_t'(0)) begin
      cfg_count = count_t'(1);
    end else if (cfg_count > count_t'(MaxStreams)) begin
      cfg_count = count_t'(MaxStreams);
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc && idx_ok) begin
      mem_q[in_idx[SlotW-1:0]] <= {in_stamp, in_handle};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[ptr_q];
    end
  end

  // Sequencer, accumulators and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      slot_valid_q <= '0;
      count_q      <= count_t'(1);
      window_q     <= '0;
      seq_q        <= '0;
      ptr_q        <= '0;
      min_q        <= '0;
      max_q        <= '0;
      scan_vld_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_stream_q <= '0;
      out_handle_q <= '0;
      out_seq_q    <= '0;
      out_stamp_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      scan_vld_q <= (state_q == StScan);

      // Result taken and not replaced in the same cycle
      if (out_valid_q && m_axis_tready && !load_out) begin
        out_valid_q <= 1'b0;
      end

      // Min/max over stamps coming back from the sweep
      if (scan_vld_q) begin
        if (rd_stamp < min_q) min_q <= rd_stamp;
        if (rd_stamp > max_q) max_q <= rd_stamp;
      end

      // Stream count write restarts slots and sequence
      if (count_wr) begin
        count_q      <= cfg_count;
        slot_valid_q <= '0;
        seq_q        <= '0;
      end else begin
        unique case (state_q)
          StIdle: begin
            if (in_acc && idx_ok) begin
              slot_valid_q <= valid_upd;
              min_q        <= '1;
              max_q        <= '0;
              ptr_q        <= '0;
              if (all_valid) begin
                state_q <= StScan;
              end
            end
          end
          StScan: begin
            if (ptr_q == last_idx) begin
              ptr_q   <= '0;
              state_q <= StDrain;
            end else begin
              ptr_q <= ptr_q + slot_t'(1);
            end
          end
          StDrain: begin
            state_q <= StCheck;
          end
          StCheck: begin
            ptr_q   <= '0;
            state_q <= (spread < window_q) ? StRead : StIdle;
          end
          StRead: begin
            state_q <= StSend;
          end
          StSend: begin
            if (load_out) begin
              out_valid_q  <= 1'b1;
              out_stream_q <= ptr_q;
              out_handle_q <= rd_handle;
              out_seq_q    <= seq_q;
              out_stamp_q  <= min_q;
              out_last_q   <= load_last;
              if (load_last) begin
                slot_valid_q <= '0;
                seq_q        <= seq_q + seq_t'(1);
                state_q      <= StIdle;
              end else begin
                ptr_q   <= ptr_q + slot_t'(1);
                state_q <= StRead;
              end
            end
          end
          default: state_q <= StIdle;
        endcase
      end

      // Window write
      if (cfg_we_i && (cfg_reg_e'(cfg_idx_i) == CfgSyncWindow)) begin
        window_q <= cfg_data_i[StampBits-1:0];
      end
    end
  end

  // Output packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'b0, out_stamp_q, out_seq_q, out_handle_q, out_stream_q};

  // Checks
  default disable iff (!rst_ni);

  // A finished pack leaves no slot marked valid
  a_pack_clears: assert property (@(posedge clk_i) load_last |=> slot_valid_q == '0)
    else $error("slots still valid after pack");

  // The sweep always sees at least one stamp before the compare
  a_min_le_max: assert property (@(posedge clk_i) (state_q == StCheck) |-> min_q <= max_q)
    else $error("stamp min above max at window check");

  // Each pack advances the sequence by one unless a count write resets it
  a_seq_step: assert property (@(posedge clk_i)
      (load_last && !(cfg_we_i && cfg_idx_i == CfgStreamCount))
      |=> seq_q == $past(seq_q) + seq_t'(1))
    else $error("sequence did not advance after pack");

  // Stamps are only accumulated in the cycle after a sweep read
  a_scan_read: assert property (@(posedge clk_i) scan_vld_q |-> $past(state_q == StScan))
    else $error("stamp accumulated without a sweep read");

endmodule

`default_nettype wire

// ===== tb/sv/tsws_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsws_checker
// Watches the configuration port and both streams of the timestamp window
// synchronizer, keeps its own copy of the slot store, the sequence and the
// registers, predicts every pack and compares each result field by field.
// ----------------------------------------------------------------------------
module tsws_checker
  import tsws_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [CfgDataW-1:0]  cfg_data_i,
  input  wire                 s_axis_tvalid,
  input  wire                 s_axis_tready,
  input  wire [InDataW-1:0]   s_axis_tdata,
  input  wire                 m_axis_tvalid,
  input  wire                 m_axis_tready,
  input  wire [OutDataW-1:0]  m_axis_tdata,
  input  wire                 m_axis_tlast,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         packs_o,
  output int unsigned         results_o
);

  typedef struct packed {
    slot_t   stream;
    handle_t handle;
    seq_t    seq;
    stamp_t  stamp;
    logic    last;
  } pack_entry_t;

  // Shadow registers and slot store
  count_t                 active_cnt;
  stamp_t                 window;
  logic [MaxStreams-1:0]  slot_full;
  stamp_t                 slot_ts [MaxStreams];
  handle_t                slot_hd [MaxStreams];
  seq_t                   next_seq;
  pack_entry_t            expected_q[$];

  // Register write: count is clamped to 1..MaxStreams and restarts the slots and the sequence
  task automatic apply_write(cfg_reg_e which, logic [CfgDataW-1:0] data);
    count_t req;
    if (which == CfgStreamCount) begin
      req = data[CountW-1:0];
      if (req == 0) begin
        req = count_t'(1);
      end else if (req > MaxStreams) begin
        req = count_t'(MaxStreams);
      end
      active_cnt = req;
      slot_full  = '0;
      next_seq   = '0;
    end else begin
      window = data[StampBits-1:0];
    end
  endtask

  // One accepted message: fill its slot, then see whether a pack forms
  task automatic take_message(logic [InDataW-1:0] d);
    logic [3:0]  idx;
    stamp_t      lo;
    stamp_t      hi;
    pack_entry_t e;
    idx = d[3:0];
    if (idx >= active_cnt) return;  // stream not configured
    slot_full[idx[SlotW-1:0]] = 1'b1;
    slot_ts[idx[SlotW-1:0]]   = d[51:4];
    slot_hd[idx[SlotW-1:0]]   = d[83:52];
    lo = '1;
    hi = '0;
    for (int i = 0; i < active_cnt; i++) begin
      if (!slot_full[i]) return;
      if (slot_ts[i] < lo) lo = slot_ts[i];
      if (slot_ts[i] > hi) hi = slot_ts[i];
    end
    if (!(hi - lo < window)) return;
    for (int i = 0; i < active_cnt; i++) begin
      e.stream = slot_t'(i);
      e.handle = slot_hd[i];
      e.seq    = next_seq;
      e.stamp  = lo;
      e.last   = (i + 1 == active_cnt);
      expected_q = {expected_q, e};
    end
    slot_full = '0;
    next_seq  = next_seq + seq_t'(1);
    packs_o++;
  endtask

  // One accepted result against the oldest expectation
  task automatic check_result(logic [OutDataW-1:0] d, logic last);
    pack_entry_t want;
    pack_entry_t got;
    bit          have;
    got.stream = d[2:0];
    got.handle = d[34:3];
    got.seq    = d[66:35];
    got.stamp  = d[114:67];
    got.last   = last;
    results_o++;
    have = expected_q.size() != 0;
    if (have) want = expected_q.pop_front();
    if (!have || got !== want) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        if (!have) begin
          $display("%0t: result with nothing expected: stream %0d handle %h seq %0d stamp %h last %0b",
                   $realtime, got.stream, got.handle, got.seq, got.stamp, got.last);
        end else begin
          $display("%0t: result mismatch (expected/actual): stream %0d/%0d handle %h/%h",
                   $realtime, want.stream, got.stream, want.handle, got.handle);
          $display("    seq %0d/%0d stamp %h/%h last %0b/%0b",
                   want.seq, got.seq, want.stamp, got.stamp, want.last, got.last);
        end
      end
    end
  endtask

  // Results are checked before new messages are predicted in the same cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_cnt   = count_t'(1);
      window       = '0;
      slot_full    = '0;
      next_seq     = '0;
      fail_count_o = 0;
      packs_o      = 0;
      results_o    = 0;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tlast);
      if (cfg_we_i) apply_write(cfg_reg_e'(cfg_idx_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) take_message(s_axis_tdata);
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the timestamp window synchronizer. A directed
// opening covers reset defaults, clamped stream counts, zero and full windows
// and ignored streams; random phases then feed mostly complete stream rounds
// with stamps around the window edge, mixed with stray and unconfigured
// messages, under bursty input and random output backpressure.
// ----------------------------------------------------------------------------
module tb;
  import tsws_pkg::*;

  localparam int unsigned RandItems   = 170;
  localparam int unsigned DrainCycles = 3 * MaxStreams + 16;

  typedef enum int unsigned {
    RxFree,
    RxCoin,
    RxStarve,
    RxMostly
  } rx_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned pack_count;
  int unsigned result_count;

  // Stimulus bookkeeping
  count_t      cur_count = count_t'(1);
  stamp_t      cur_window = '0;
  int unsigned burst_left = 0;
  int unsigned msgs_sent = 0;
  int unsigned msgs_ignored = 0;
  int unsigned settings_used = 0;
  rx_mode_e    rx_mode = RxFree;
  int unsigned rx_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  timestamp_window_synchronizer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  tsws_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .packs_o      (pack_count),
    .results_o    (result_count)
  );

  // Result side backpressure: modes of random length
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(10, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RxFree:   m_axis_tready <= 1'b1;
      RxCoin:   m_axis_tready <= 1'($urandom_range(0, 1));
      RxStarve: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default:  m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Bursts of random length separated by random gaps
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic send_message(logic [3:0] idx, stamp_t ts, handle_t hd);
    pace_sender();
    s_axis_tdata  <= {4'b0, hd, ts, idx};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (idx < cur_count) msgs_sent++;
    else msgs_ignored++;
  endtask

  // Stop sending, wait for every expected result, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e which, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= which;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (which == CfgStreamCount) begin
      cur_count = data[CountW-1:0];
      if (cur_count == 0) cur_count = count_t'(1);
      else if (cur_count > MaxStreams) cur_count = count_t'(MaxStreams);
    end else begin
      cur_window = data[StampBits-1:0];
    end
    settings_used++;
  endtask

  function automatic stamp_t rand_stamp();
    return {16'($urandom_range(0, 16'hFFFF)), $urandom};
  endfunction

  // One message per configured stream, shuffled, stamps spread around the window
  task automatic send_round();
    int unsigned order [MaxStreams];
    int unsigned j;
    int unsigned tmp;
    int unsigned bound;
    stamp_t      base;
    for (int i = 0; i < MaxStreams; i++) order[i] = i;
    for (int i = cur_count - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    if (cur_window == 0) begin
      bound = $urandom_range(0, 100);
    end else begin
      bound = (cur_window > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : cur_window[31:0];
      if ($urandom_range(0, 1) == 0 && cur_window <= 48'hFFFF_FFFF) bound = bound - 1;
    end
    base = {1'b0, 15'($urandom_range(0, 15'h7FFF)), $urandom};
    for (int i = 0; i < cur_count; i++) begin
      send_message(4'(order[i]), base + $urandom_range(0, bound), $urandom);
    end
  endtask

  initial begin
    stamp_t      s0;
    int unsigned pick;
    logic [CfgDataW-1:0] cnt_data;
    logic [CfgDataW-1:0] win_data;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgStreamCount;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset defaults: one stream and a zero window never pack; high index ignored
    send_message(4'd0, rand_stamp(), $urandom);
    send_message(4'hF, '1, '1);
    drain();

    // Count zero acts as one; full window packs single messages at both extremes
    write_reg(CfgStreamCount, '0);
    write_reg(CfgSyncWindow, '1);
    send_message(4'd0, '0, '0);
    send_message(4'd0, '1, '1);
    drain();

    // Count above the maximum acts as eight; window of one needs equal stamps
    write_reg(CfgStreamCount, '1);
    write_reg(CfgSyncWindow, 48'd1);
    s0 = rand_stamp() >> 1;
    for (int i = 0; i < 7; i++) send_message(4'(i), s0, $urandom);
    send_message(4'd7, s0 + 1'b1, $urandom);  // spread equals window: no pack
    send_message(4'd7, s0, $urandom);         // replaced slot completes the pack
    send_message(4'd8, s0, $urandom);
    drain();

    // Window write keeps partially filled slots
    s0 = rand_stamp() >> 1;
    for (int i = 0; i < 4; i++) send_message(4'(i), s0, $urandom);
    drain();
    write_reg(CfgSyncWindow, 48'd2);
    for (int i = 4; i < 8; i++) send_message(4'(i), s0 + 1'b1, $urandom);
    drain();

    // Random phases, each under a fresh register setting
    while (msgs_sent + msgs_ignored < RandItems) begin
      cnt_data = 48'({$urandom, $urandom});
      case ($urandom_range(0, 5))
        0:       cnt_data[CountW-1:0] = 4'd1;
        1:       cnt_data[CountW-1:0] = 4'd8;
        2:       cnt_data[CountW-1:0] = 4'd0;
        3:       cnt_data[CountW-1:0] = 4'hF;
        default: cnt_data[CountW-1:0] = 4'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 9))
        0:       win_data = '0;
        1:       win_data = 48'd1;
        2:       win_data = '1;
        3, 4:    win_data = 48'($urandom_range(1, 64));
        5, 6:    win_data = 48'($urandom_range(1, 1 << 20));
        default: win_data = 48'({$urandom, $urandom});
      endcase
      drain();
      write_reg(CfgStreamCount, cnt_data);
      write_reg(CfgSyncWindow, win_data);
      repeat ((win_data == 0) ? 4 : $urandom_range(8, 16)) begin
        if (msgs_sent + msgs_ignored >= RandItems) break;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_round();
        end else if (pick < 85) begin
          send_message(4'($urandom_range(cur_count, 15)), rand_stamp(), $urandom);
        end else if (pick < 97) begin
          send_message(4'($urandom_range(0, cur_count - 1)), rand_stamp(), $urandom);
        end else begin
          drain();
        end
      end
    end

    drain();
    $display("summary: %0d messages buffered, %0d ignored, %0d register settings",
             msgs_sent, msgs_ignored, settings_used);
    $display("summary: %0d packs formed, %0d results checked, %0d mismatches",
             pack_count, result_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
